FILE: rtl/lsbf_pkg.sv
// Shared types, widths and helpers for the streamline box filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package lsbf_pkg;

  localparam int unsigned STORE_AW = 16;
  localparam int unsigned TEX_W    = 8;
  localparam int unsigned ACC_W    = 40;
  localparam int unsigned HIT_W    = 16;
  localparam int unsigned INT_W    = 18;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned WSUM_W   = 16;
  localparam int unsigned DIV_NW   = 42;
  localparam int unsigned DIV_DW   = 17;
  localparam int unsigned ACCM_W   = ACC_W + HIT_W;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_WADD   = 3'd1,
    OP_COMMIT = 3'd2,
    OP_SLIDE  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic               first_point;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] enter_x;
    logic signed [15:0] enter_y;
    logic signed [15:0] leave_x;
    logic signed [15:0] leave_y;
    logic [7:0]         texel_value;
  } in_item_t;

  typedef struct packed {
    logic signed [17:0] intensity;
    logic               pixel_in_grid;
    logic               divide_fault;
  } out_item_t;

  typedef struct packed {
    logic                tex_we;
    logic [STORE_AW-1:0] tex_addr;
    logic [TEX_W-1:0]    tex_wdata;
    logic                acc_we;
    logic [STORE_AW-1:0] acc_addr;
    logic [ACCM_W-1:0]   acc_wdata;
  } store_req_t;

  // Saturate a sign and magnitude quotient to 18 bits signed.
  function automatic logic [INT_W-1:0] sat18(input logic neg, input logic [DIV_NW-1:0] q);
    logic [INT_W-1:0] r;
    if (!neg) begin
      r = (q > DIV_NW'(131071)) ? 18'h1FFFF : q[INT_W-1:0];
    end else begin
      r = (q > DIV_NW'(131072)) ? 18'h20000 : (~q[INT_W-1:0] + 18'd1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/lsbf_store.sv
// Texture memory and accumulator/hit memory, each with a registered read.
// Depends on lsbf_pkg for the request type and widths.
`timescale 1ns / 1ps
module lsbf_store (
  input  logic                                  clk_i,
  input  lsbf_pkg::store_req_t                  req_i,
  output logic [lsbf_pkg::TEX_W-1:0]            tex_rdata_o,
  output logic [lsbf_pkg::ACCM_W-1:0]           acc_rdata_o
);
  import lsbf_pkg::*;

  localparam int unsigned DEPTH = 2 ** STORE_AW;

  logic [TEX_W-1:0]  tex_mem [DEPTH];
  logic [ACCM_W-1:0] acc_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.tex_we) begin
      tex_mem[req_i.tex_addr] <= req_i.tex_wdata;
    end
    tex_rdata_o <= tex_mem[req_i.tex_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.acc_we) begin
      acc_mem[req_i.acc_addr] <= req_i.acc_wdata;
    end
    acc_rdata_o <= acc_mem[req_i.acc_addr];
  end

endmodule

FILE: rtl/lsbf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on lsbf_pkg for operand widths.
`timescale 1ns / 1ps
module lsbf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lsbf_pkg::DIV_NW-1:0]   num_i,
  input  logic [lsbf_pkg::DIV_DW-1:0]   den_i,
  output logic                          done_o,
  output logic [lsbf_pkg::DIV_NW-1:0]   quo_o
);
  import lsbf_pkg::*;

  localparam int unsigned CW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] n_q, n_d;
  logic [DIV_DW:0]   rem_q, rem_d;
  logic [DIV_DW-1:0] den_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [DIV_DW:0]   trial;

  always_comb begin
    n_d    = n_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    trial  = {rem_q[DIV_DW-1:0], n_q[DIV_NW-1]};
    if (start_i) begin
      n_d    = num_i;
      rem_d  = '0;
      cnt_d  = CW'(DIV_NW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        n_d   = {n_q[DIV_NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        n_d   = {n_q[DIV_NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule

FILE: rtl/lic_streamline_box_filter.sv
// Top level of the streamline box filter: sequencer, window registers, output register.
// Depends on lsbf_pkg, lsbf_store and lsbf_div.
//
//   channel   signals                          direction
//   input     in_valid_i in_ready_o in_item_i  in_item_t into the block
//   output    out_valid_o out_ready_i out_item_o out_item_t out of the block
//
// Load texel and window add pass through accept, the read states RDA and RDB, operand and write-back.
// Commit, slide and read also wait on the 42-step divider between operand and write-back;
// a faulted or off-grid one skips the divider.
// After reset a clearing pass walks all 65536 store entries, one a cycle, before
// the first item is taken. A waiting result stalls only the final write-back cycle.
`timescale 1ns / 1ps
module lic_streamline_box_filter #(
  parameter int unsigned GRID_W = 256,
  parameter int unsigned GRID_H = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lsbf_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lsbf_pkg::out_item_t  out_item_o
);
  import lsbf_pkg::*;

  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_RDA  = 7'b0000100,
    ST_RDB  = 7'b0001000,
    ST_EXEC = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } st_e;

  function automatic logic [STORE_AW:0] cell_f(input logic [15:0] x, input logic [15:0] y);
    logic [8:0]  i, j;
    logic        ix, iy;
    logic [19:0] lin;
    i   = x[15] ? 9'd0 : x[14:6];
    j   = y[15] ? 9'd0 : y[14:6];
    ix  = x[15] ? ((x[15:6] == 10'h3FF) && (x[5:0] != 6'd0)) : ({2'b0, i} < 11'(GRID_W));
    iy  = y[15] ? ((y[15:6] == 10'h3FF) && (y[5:0] != 6'd0)) : ({2'b0, j} < 11'(GRID_H));
    lin = 20'(j) * 20'(GRID_W) + 20'(i);
    return {ix && iy, lin[STORE_AW-1:0]};
  endfunction

  st_e                 st_q, st_d;
  in_item_t            item_q;
  logic [STORE_AW-1:0] cen_addr_q, ent_addr_q, lea_addr_q, clr_q;
  logic                cen_in_q, ent_in_q, lea_in_q;
  logic [TEX_W-1:0]    tex_a_q;
  logic [ACC_W-1:0]    acc_q;
  logic [HIT_W-1:0]    hit_q;
  logic [WSUM_W-1:0]   wsum_q, wsum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_new_q;
  logic [INT_W-1:0]    run_q, run_d;
  logic                neg_q, fault_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic [STORE_AW:0]   c_cen, c_ent, c_lea;
  store_req_t          req;
  logic [TEX_W-1:0]    tex_rdata;
  logic [ACCM_W-1:0]   acc_rdata;
  logic                div_start, div_done;
  logic [DIV_NW-1:0]   div_num, div_quo;
  logic [DIV_DW-1:0]   div_den;
  logic                out_free, fin_fire;
  op_e                 op;

  // exec-stage signals
  logic [TEX_W-1:0]    te, tl;
  logic [CNT_W:0]      c_sl;
  logic signed [9:0]   diff;
  logic [ACC_W-1:0]    mag;
  logic [HIT_W-1:0]    dv;
  logic                x_fault, x_neg, x_div;

  // finish-stage signals
  logic [INT_W-1:0]    res;
  logic signed [18:0]  step19, sum19;
  logic signed [40:0]  acc41;
  logic [ACC_W-1:0]    acc_new;
  logic [HIT_W-1:0]    hit_new;
  logic [WSUM_W:0]     ws17;
  logic                act;

  assign op       = op_e'(item_q.operation);
  assign c_cen    = cell_f(in_item_i.center_x, in_item_i.center_y);
  assign c_ent    = cell_f(in_item_i.enter_x, in_item_i.enter_y);
  assign c_lea    = cell_f(in_item_i.leave_x, in_item_i.leave_y);
  assign out_free = !out_valid_q || out_ready_i;
  assign fin_fire = (st_q == ST_FIN) && out_free;
  assign act      = cen_in_q && !fault_q;

  // exec: operands for the divider
  always_comb begin
    te      = ent_in_q ? tex_a_q : '0;
    tl      = lea_in_q ? tex_rdata : '0;
    c_sl    = {1'b0, cnt_q};
    if (ent_in_q && (cnt_q != 7'h7F)) begin
      c_sl = c_sl + 8'd1;
    end
    if (lea_in_q && (c_sl != 8'd0)) begin
      c_sl = c_sl - 8'd1;
    end
    diff    = $signed({2'b0, te}) - $signed({2'b0, tl});
    mag     = '0;
    dv      = '0;
    x_fault = 1'b0;
    x_neg   = 1'b0;
    x_div   = 1'b0;
    unique case (op)
      OP_COMMIT: begin
        x_fault = cen_in_q && (cnt_q == '0);
        mag     = ACC_W'({wsum_q, 8'd0});
        dv      = HIT_W'(cnt_q);
        x_div   = cen_in_q && !x_fault;
      end
      OP_SLIDE: begin
        x_fault = cen_in_q && (c_sl == '0);
        x_neg   = diff[9];
        mag     = ACC_W'({(x_neg ? 10'(-diff) : 10'(diff)), 8'd0});
        dv      = HIT_W'(c_sl);
        x_div   = cen_in_q && !x_fault;
      end
      OP_READ: begin
        x_fault = cen_in_q && (hit_q == '0);
        x_neg   = acc_q[ACC_W-1];
        mag     = x_neg ? (~acc_q + ACC_W'(1)) : acc_q;
        dv      = hit_q;
        x_div   = cen_in_q && !x_fault;
      end
      default: begin
        x_div = 1'b0;
      end
    endcase
    div_start = (st_q == ST_EXEC) && x_div;
    div_num   = {1'b0, mag, 1'b0} + DIV_NW'(dv);
    div_den   = {dv, 1'b0};
  end

  // finish: results and write-back values
  always_comb begin
    res     = '0;
    step19  = $signed({2'b0, div_quo[16:0]});
    if (neg_q) begin
      step19 = -step19;
    end
    sum19   = $signed({run_q[INT_W-1], run_q}) + step19;
    wsum_d  = wsum_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    ws17    = '0;
    unique case (op)
      OP_COMMIT: res = sat18(1'b0, div_quo);
      OP_SLIDE: begin
        if (sum19 > 19'sd131071) begin
          res = 18'h1FFFF;
        end else if (sum19 < -19'sd131072) begin
          res = 18'h20000;
        end else begin
          res = sum19[INT_W-1:0];
        end
      end
      OP_READ: res = sat18(neg_q, div_quo);
      default: res = '0;
    endcase
    if (!act) begin
      res = '0;
    end
    acc41   = $signed({acc_q[ACC_W-1], acc_q}) + 41'($signed(res));
    if (acc41[40] != acc41[39]) begin
      acc_new = acc41[40] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_new = acc41[ACC_W-1:0];
    end
    hit_new = (hit_q == '1) ? hit_q : hit_q + HIT_W'(1);
    if (op == OP_WADD) begin
      if (item_q.first_point) begin
        wsum_d = '0;
        cnt_d  = '0;
      end
      if (cen_in_q) begin
        ws17   = {1'b0, wsum_d} + 17'(tex_a_q);
        wsum_d = ws17[WSUM_W] ? '1 : ws17[WSUM_W-1:0];
        if (cnt_d != '1) begin
          cnt_d = cnt_d + CNT_W'(1);
        end
      end
    end else if (act && ((op == OP_COMMIT) || (op == OP_SLIDE))) begin
      run_d = res;
      if (op == OP_SLIDE) begin
        cnt_d = cnt_new_q;
      end
    end
  end

  // memory requests
  always_comb begin
    req = '0;
    req.tex_addr = cen_addr_q;
    req.acc_addr = cen_addr_q;
    unique case (st_q)
      ST_CLR: begin
        req.tex_we   = 1'b1;
        req.acc_we   = 1'b1;
        req.tex_addr = clr_q;
        req.acc_addr = clr_q;
      end
      ST_RDA: req.tex_addr = (op == OP_SLIDE) ? ent_addr_q : cen_addr_q;
      ST_RDB: req.tex_addr = lea_addr_q;
      ST_FIN: begin
        req.tex_we    = fin_fire && (op == OP_LOAD) && cen_in_q;
        req.tex_wdata = item_q.texel_value;
        req.acc_we    = fin_fire && act && ((op == OP_COMMIT) || (op == OP_SLIDE));
        req.acc_wdata = {acc_new, hit_new};
      end
      default: req.tex_we = 1'b0;
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLR:  st_d = (clr_q == '1) ? ST_IDLE : ST_CLR;
      ST_IDLE: st_d = in_valid_i ? ST_RDA : ST_IDLE;
      ST_RDA:  st_d = ST_RDB;
      ST_RDB:  st_d = ST_EXEC;
      ST_EXEC: st_d = x_div ? ST_DIV : ST_FIN;
      ST_DIV:  st_d = div_done ? ST_FIN : ST_DIV;
      ST_FIN:  st_d = out_free ? ST_IDLE : ST_FIN;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLR;
      clr_q       <= '0;
      wsum_q      <= '0;
      cnt_q       <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_CLR) begin
        clr_q <= clr_q + STORE_AW'(1);
      end
      if (fin_fire) begin
        wsum_q      <= wsum_d;
        cnt_q       <= cnt_d;
        run_q       <= run_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((st_q == ST_IDLE) && in_valid_i) begin
      item_q     <= in_item_i;
      cen_in_q   <= c_cen[STORE_AW];
      cen_addr_q <= c_cen[STORE_AW-1:0];
      ent_in_q   <= c_ent[STORE_AW];
      ent_addr_q <= c_ent[STORE_AW-1:0];
      lea_in_q   <= c_lea[STORE_AW];
      lea_addr_q <= c_lea[STORE_AW-1:0];
    end
    if (st_q == ST_RDB) begin
      tex_a_q <= tex_rdata;
      acc_q   <= acc_rdata[ACCM_W-1:HIT_W];
      hit_q   <= acc_rdata[HIT_W-1:0];
    end
    if (st_q == ST_EXEC) begin
      fault_q   <= x_fault;
      neg_q     <= x_neg;
      cnt_new_q <= c_sl[CNT_W-1:0];
    end
    if (fin_fire) begin
      out_q.intensity     <= $signed(res);
      out_q.pixel_in_grid <= cen_in_q && (item_q.operation <= OP_READ);
      out_q.divide_fault  <= fault_q && cen_in_q &&
                             ((op == OP_COMMIT) || (op == OP_SLIDE) || (op == OP_READ));
    end
  end

  lsbf_store u_store (
    .clk_i       (clk_i),
    .req_i       (req),
    .tex_rdata_o (tex_rdata),
    .acc_rdata_o (acc_rdata)
  );

  lsbf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: sim/tb_lic_streamline_box_filter.sv
// Testbench for lic_streamline_box_filter: drives load, window, commit, slide and
// read transfers and checks each result against a predictor of the box filter.
// Depends on lsbf_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_lic_streamline_box_filter;
  import lsbf_pkg::*;

  localparam int GW = 256;
  localparam int GH = 256;
  localparam int STALL_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;

  lic_streamline_box_filter #(.GRID_W(GW), .GRID_H(GH)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // filter state mirror
  logic [7:0] tex_mem [int];
  longint acc_mem [int];
  int hit_mem [int];
  int wsum;
  int vcount;
  int run_int;

  out_item_t expected_q [$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int idle_in_pct = 0;
  int idle_out_pct = 0;
  bit hold_out = 1'b0;
  int quiet_cycles = 0;

  function automatic bit cell_of(logic signed [15:0] x, logic signed [15:0] y,
                                 output int addr);
    int i;
    int j;
    i = int'(x) / 64;
    j = int'(y) / 64;
    addr = 0;
    if (i < 0 || i >= GW || j < 0 || j >= GH) return 1'b0;
    addr = (j * GW + i) & 16'hFFFF;
    return 1'b1;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint m;
    longint q;
    m = (n < 0) ? -n : n;
    q = (m * 2 + d) / (2 * d);
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int texel(logic signed [15:0] x, logic signed [15:0] y);
    int a;
    if (!cell_of(x, y, a)) return 0;
    return tex_mem.exists(a) ? int'(tex_mem[a]) : 0;
  endfunction

  function automatic void accumulate(int a, longint v);
    longint cur;
    cur = acc_mem.exists(a) ? acc_mem[a] : 0;
    acc_mem[a] = clamp(cur + v, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
    if (!hit_mem.exists(a)) hit_mem[a] = 0;
    if (hit_mem[a] < 65535) hit_mem[a]++;
  endfunction

  function automatic out_item_t filter_step(in_item_t it);
    out_item_t r;
    int a;
    int ea;
    int la;
    int cnt;
    int h;
    bit ok;
    longint res;
    ok = cell_of(it.center_x, it.center_y, a);
    res = 0;
    r = '0;
    case (it.operation)
      OP_LOAD: if (ok) tex_mem[a] = it.texel_value;
      OP_WADD: begin
        if (it.first_point) begin
          wsum = 0;
          vcount = 0;
        end
        if (ok) begin
          wsum = wsum + texel(it.center_x, it.center_y);
          if (wsum > 65535) wsum = 65535;
          if (vcount < 127) vcount++;
        end
      end
      OP_COMMIT: if (ok) begin
        if (vcount == 0) r.divide_fault = 1'b1;
        else begin
          res = clamp(round_div(longint'(wsum) * 256, vcount), -131072, 131071);
          run_int = int'(res);
          accumulate(a, res);
        end
      end
      OP_SLIDE: if (ok) begin
        cnt = vcount;
        if (cell_of(it.enter_x, it.enter_y, ea) && cnt < 127) cnt++;
        if (cell_of(it.leave_x, it.leave_y, la) && cnt > 0) cnt--;
        if (cnt == 0) r.divide_fault = 1'b1;
        else begin
          vcount = cnt;
          res = round_div(longint'(texel(it.enter_x, it.enter_y)
                - texel(it.leave_x, it.leave_y)) * 256, cnt);
          res = clamp(longint'(run_int) + res, -131072, 131071);
          run_int = int'(res);
          accumulate(a, res);
        end
      end
      OP_READ: if (ok) begin
        h = hit_mem.exists(a) ? hit_mem[a] : 0;
        if (h == 0) r.divide_fault = 1'b1;
        else res = clamp(round_div(acc_mem[a], h), -131072, 131071);
      end
      default: ok = 1'b0;
    endcase
    r.intensity = res[17:0];
    r.pixel_in_grid = ok;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch on result %0d: %s got %0d expected %0d", received, what, got, want);
  endtask

  // drive one transfer and queue its expected result
  task automatic send_item(in_item_t it);
    while (idle_in_pct > 0 && $urandom_range(99) < idle_in_pct) @(negedge clk_i);
    in_item_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(filter_step(it));
    sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= !hold_out && !(idle_out_pct > 0 && $urandom_range(99) < idle_out_pct);
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) report_mismatch("unexpected transfer", 0, 0);
      else begin
        automatic out_item_t e = expected_q.pop_front();
        if (out_item_o.intensity !== e.intensity)
          report_mismatch("intensity", out_item_o.intensity, e.intensity);
        if (out_item_o.pixel_in_grid !== e.pixel_in_grid)
          report_mismatch("pixel_in_grid", out_item_o.pixel_in_grid, e.pixel_in_grid);
        if (out_item_o.divide_fault !== e.divide_fault)
          report_mismatch("divide_fault", out_item_o.divide_fault, e.divide_fault);
      end
      received++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("** lic_streamline_box_filter: FAILED **");
      $finish;
    end
  end

  function automatic in_item_t make_item(op_e op, logic fp, int cx, int cy);
    in_item_t it;
    it = '0;
    it.operation = op;
    it.first_point = fp;
    it.center_x = 16'(cx);
    it.center_y = 16'(cy);
    return it;
  endfunction

  // coordinate biased into a small patch of the grid, sometimes anywhere
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(9))
      0: return 16'($urandom());
      1: return 16'($urandom_range(65535 - 63, 65535));
      default: return 16'($urandom_range(0, 8 * 64 - 1));
    endcase
  endfunction

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    in_item_t it;
    send_item(make_item(OP_READ, 0, 64, 64));
    send_item(make_item(OP_COMMIT, 0, 64, 64));
    it = make_item(OP_LOAD, 0, 64, 64);
    it.texel_value = 8'hFF;
    send_item(it);
    it = make_item(OP_LOAD, 0, 128, 64);
    it.texel_value = 8'h01;
    send_item(it);
    it = make_item(OP_LOAD, 0, -32, 0);
    it.texel_value = 8'hAA;
    send_item(it);
    it = make_item(OP_LOAD, 0, 255 * 64 + 63, 255 * 64 + 63);
    it.texel_value = 8'h55;
    send_item(it);
    send_item(make_item(OP_LOAD, 0, 256 * 64, 0));
    send_item(make_item(OP_WADD, 1, 64, 64));
    send_item(make_item(OP_WADD, 0, 128, 64));
    send_item(make_item(OP_WADD, 0, -32768, 32767));
    send_item(make_item(OP_COMMIT, 0, 64, 64));
    send_item(make_item(OP_COMMIT, 0, -64, 64));
    it = make_item(OP_SLIDE, 0, 64, 64);
    it.enter_x = 16'sd128;
    it.enter_y = 16'sd64;
    it.leave_x = 16'sd64;
    it.leave_y = 16'sd64;
    send_item(it);
    it.enter_x = -16'sd32768;
    it.leave_x = 16'sd32767;
    send_item(it);
    send_item(make_item(OP_WADD, 1, -1, -1));
    it = make_item(OP_SLIDE, 1, 64, 64);
    it.enter_x = 16'sd32767;
    it.leave_x = 16'sd64;
    it.leave_y = 16'sd64;
    send_item(it);
    send_item(make_item(OP_READ, 0, 64, 64));
    send_item(make_item(OP_READ, 0, 65, 127));
    it = make_item(op_e'(3'd5), 1, 64, 64);
    it.enter_x = '1;
    it.enter_y = '1;
    it.leave_x = '1;
    it.leave_y = '1;
    it.texel_value = '1;
    send_item(it);
    send_item(make_item(op_e'(3'd7), 0, 0, 0));
    send_item(make_item(op_e'(3'd6), 0, 0, 0));
  endtask

  // well-formed streamline: window sum, commit, slides, final read
  task automatic send_streamline();
    in_item_t it;
    int n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      it = make_item(OP_WADD, k == 0, 0, 0);
      it.center_x = rand_coord();
      it.center_y = rand_coord();
      send_item(it);
    end
    it = make_item(OP_COMMIT, 0, 0, 0);
    it.center_x = rand_coord();
    it.center_y = rand_coord();
    send_item(it);
    n = $urandom_range(1, 5);
    for (int k = 0; k < n; k++) begin
      it = make_item(OP_SLIDE, 1'($urandom_range(1)), 0, 0);
      it.center_x = rand_coord();
      it.center_y = rand_coord();
      it.enter_x = rand_coord();
      it.enter_y = rand_coord();
      it.leave_x = rand_coord();
      it.leave_y = rand_coord();
      send_item(it);
    end
    it = make_item(OP_READ, 0, 0, 0);
    it.center_x = rand_coord();
    it.center_y = rand_coord();
    send_item(it);
  endtask

  task automatic send_noise();
    in_item_t it;
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = raw[$bits(in_item_t)-1:0];
    if ($urandom_range(3) != 0) begin
      it.center_x = rand_coord();
      it.center_y = rand_coord();
    end
    send_item(it);
  endtask

  task automatic test_random(int count);
    int start;
    start = sent;
    while (sent - start < count) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          automatic in_item_t it = make_item(OP_LOAD, 0, 0, 0);
          it.center_x = rand_coord();
          it.center_y = rand_coord();
          it.texel_value = 8'($urandom());
          send_item(it);
        end
        3: send_noise();
        default: send_streamline();
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_out = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        hold_out = 1'b0;
      end
      test_random(12);
    join
    drain();
  endtask

  initial begin
    tex_mem.delete();
    acc_mem.delete();
    hit_mem.delete();
    wsum = 0;
    vcount = 0;
    run_int = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    drain();
    idle_in_pct = 15;
    idle_out_pct = 79;
    test_random(400);
    test_backpressure();
    idle_in_pct = 79;
    idle_out_pct = 15;
    test_random(400);
    drain();
    idle_in_pct = 0;
    idle_out_pct = 0;
    test_random(400);
    drain();
    repeat (100) @(posedge clk_i);
    $display("covered %0d transfers in, %0d results out: loads, windows, commits,", sent, received);
    $display("slides, reads, unused codes, off-grid points and zero divisors");
    if (errors == 0) begin
      $display("** lic_streamline_box_filter: PASSED **");
    end else begin
      $display("** lic_streamline_box_filter: FAILED **");
    end
    $finish;
  end

endmodule
